FILE: src/sfr_pkg.sv
// sfr_pkg: shared constants and types for the streaming find/replace core.
// Used by every module under src; has no dependencies of its own.
package sfr_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int BYTE_W      = 8;
	localparam int WIN_W       = MAX_PATTERN * BYTE_W;
	localparam int LEN_W       = 4;
	localparam int IDX_W       = 3;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = 2;
	localparam int Q_FILL_W    = 3;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// one emit job: cnt bytes of data, byte 0 first; cnt zero only as an end marker
	typedef struct packed {
		logic [WIN_W-1:0] data;
		logic [LEN_W-1:0] cnt;
		logic             last;
	} sfr_job_t;

endpackage

FILE: src/sfr_front.sv
// sfr_front: configuration registers, pending window and match decision.
// Turns each accepted text word into at most one emit job. Depends on sfr_pkg.
module sfr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [sfr_pkg::WIN_W-1:0]    cfg_wr_data,
	input  logic                         text_valid,
	input  logic [sfr_pkg::BYTE_W-1:0]   text_byte,
	input  logic                         text_last,
	input  logic                         q_full,
	output logic                         text_stall,
	output logic                         push,
	output sfr_pkg::sfr_job_t            push_job
);

	logic [sfr_pkg::WIN_W-1:0]       pat_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]       pat_len_q;
	logic [sfr_pkg::WIN_W-1:0]       rep_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]       rep_len_q;
	logic [sfr_pkg::WIN_W-1:0]       win_q;
	logic [sfr_pkg::LEN_W-1:0]       cnt_q;

	logic [sfr_pkg::LEN_W-1:0]       plen;
	logic [sfr_pkg::LEN_W-1:0]       rlen;
	logic [sfr_pkg::LEN_W-1:0]       cnt_new;
	logic [sfr_pkg::LEN_W-1:0]       drop_n;
	logic [sfr_pkg::WIN_W-1:0]       win_new;
	logic [sfr_pkg::WIN_W-1:0]       win_shift;
	logic [sfr_pkg::MAX_PATTERN-1:0] byte_ok;
	logic                            hit;
	logic                            accept;
	logic [sfr_pkg::WIN_W-1:0]       win_nxt;
	logic [sfr_pkg::LEN_W-1:0]       cnt_nxt;
	sfr_pkg::sfr_job_t               job;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= sfr_pkg::LEN_W'(1);
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (sfr_pkg::cfg_reg_t'(cfg_index))
				sfr_pkg::REG_PATTERN_BYTES:      pat_bytes_q <= cfg_wr_data;
				sfr_pkg::REG_PATTERN_LENGTH:     pat_len_q   <= cfg_wr_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_wr_data;
				sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_wr_data[sfr_pkg::LEN_W-1:0];
				default:                         pat_len_q   <= pat_len_q;
			endcase
		end
	end

	// effective lengths: pattern at least one, both capped at the window size
	always_comb begin
		if (pat_len_q == '0)
			plen = sfr_pkg::LEN_W'(1);
		else if (pat_len_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN))
			plen = sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN);
		else
			plen = pat_len_q;
		if (rep_len_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN))
			rlen = sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN);
		else
			rlen = rep_len_q;
	end

	// window with the new word appended, and per-byte pattern compare
	always_comb begin
		for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
			if (sfr_pkg::LEN_W'(i) < cnt_q)
				win_new[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] =
					win_q[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
			else
				win_new[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = text_byte;
			byte_ok[i] = (sfr_pkg::LEN_W'(i) >= plen) ||
				(win_new[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] ==
				 pat_bytes_q[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]);
		end
	end

	assign cnt_new   = cnt_q + sfr_pkg::LEN_W'(1);
	assign hit       = (cnt_new == plen) && (&byte_ok);
	assign drop_n    = cnt_new - plen + sfr_pkg::LEN_W'(1);
	assign win_shift = win_new >> {drop_n, 3'b000};

	// decision: replace, send oldest bytes, flush on last, or just hold
	always_comb begin
		job.last = text_last;
		job.data = win_new;
		job.cnt  = '0;
		win_nxt  = win_new;
		cnt_nxt  = cnt_new;
		if (hit) begin
			job.data = rep_bytes_q;
			job.cnt  = rlen;
			cnt_nxt  = '0;
		end else if (text_last) begin
			job.cnt = cnt_new;
			cnt_nxt = '0;
		end else if (cnt_new >= plen) begin
			job.cnt = drop_n;
			win_nxt = win_shift;
			cnt_nxt = plen - sfr_pkg::LEN_W'(1);
		end
	end

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;
	assign push       = accept && ((job.cnt != '0) || text_last);
	assign push_job   = job;

	// pending window
	always_ff @(posedge clk) begin
		if (accept)
			win_q <= win_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (accept)
			cnt_q <= cnt_nxt;
	end

endmodule

FILE: src/sfr_queue.sv
// sfr_queue: small job queue between the decision front and the output back.
// Depends on sfr_pkg for the job type and depth.
module sfr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfr_pkg::sfr_job_t push_job,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output sfr_pkg::sfr_job_t head
);

	sfr_pkg::sfr_job_t                 mem_q [sfr_pkg::Q_DEPTH];
	logic [sfr_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [sfr_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [sfr_pkg::Q_FILL_W-1:0]      fill_q;

	assign full  = (fill_q == sfr_pkg::Q_FILL_W'(sfr_pkg::Q_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + sfr_pkg::Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + sfr_pkg::Q_PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + sfr_pkg::Q_FILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - sfr_pkg::Q_FILL_W'(1);
		end
	end

endmodule

FILE: src/sfr_back.sv
// sfr_back: walks the head job one byte per cycle into the output register,
// unless result_stall holds it. Depends on sfr_pkg for the job type.
module sfr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  sfr_pkg::sfr_job_t            head,
	output logic                         pop,
	input  logic                         result_stall,
	output logic                         result_valid,
	output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
	output logic                         out_valid,
	output logic                         out_last
);

	logic [sfr_pkg::IDX_W-1:0]  idx_q;
	logic                       rv_q;
	logic [sfr_pkg::BYTE_W-1:0] byte_q;
	logic                       ov_q;
	logic                       ol_q;

	logic                       load;
	logic                       take;
	logic                       marker;
	logic                       at_end;
	logic [sfr_pkg::WIN_W-1:0]  sel;

	assign load   = !rv_q || !result_stall;
	assign take   = load && !empty;
	assign marker = (head.cnt == '0);
	assign at_end = marker || (({1'b0, idx_q} + sfr_pkg::LEN_W'(1)) == head.cnt);
	assign sel    = head.data >> {idx_q, 3'b000};
	assign pop    = take && at_end;

	// byte index inside the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (take)
			idx_q <= at_end ? '0 : idx_q + sfr_pkg::IDX_W'(1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_q <= 1'b0;
		else if (load)
			rv_q <= !empty;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= marker ? '0 : sel[sfr_pkg::BYTE_W-1:0];
			ov_q   <= !marker;
			ol_q   <= head.last && at_end;
		end
	end

	assign result_valid = rv_q;
	assign out_byte     = byte_q;
	assign out_valid    = ov_q;
	assign out_last     = ol_q;

endmodule

FILE: src/streaming_find_replace_core.sv
// streaming_find_replace_core: top level of the byte stream find/replace block.
// Instantiates sfr_front, sfr_queue and sfr_back; uses sfr_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  text     | text_valid / text_stall   | text_byte[7:0], text_last
//  result   | result_valid/result_stall | out_byte[7:0], out_valid, out_last
//  config   | cfg_wr_en                 | cfg_index[1:0], cfg_wr_data[63:0]
//
// A text word is taken every cycle while the 4-entry job queue has room.
// Each word makes at most one job of 0 to 8 bytes; the output stage sends one
// result word per cycle unless result_stall holds it. A word's results pass
// through the job queue and then the output register. Reset empties the
// window and queue and loads register defaults. result_stall freezes the
// output register while it holds a result; text_stall rises only on a full queue.
module streaming_find_replace_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [sfr_pkg::WIN_W-1:0]    cfg_wr_data,
	input  logic                         text_valid,
	output logic                         text_stall,
	input  logic [sfr_pkg::BYTE_W-1:0]   text_byte,
	input  logic                         text_last,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
	output logic                         out_valid,
	output logic                         out_last
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	sfr_pkg::sfr_job_t push_job;
	sfr_pkg::sfr_job_t head;

	sfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.text_valid  (text_valid),
		.text_byte   (text_byte),
		.text_last   (text_last),
		.q_full      (q_full),
		.text_stall  (text_stall),
		.push        (push),
		.push_job    (push_job)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	sfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (head),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.out_last     (out_last)
	);

endmodule

FILE: src/sfr_checker.sv
// sfr_checker: port-level checks for streaming_find_replace_core.
// Bound to the top level below; uses sfr_pkg for widths.
module sfr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         text_valid,
	input logic                         text_stall,
	input logic                         text_last,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic [sfr_pkg::BYTE_W-1:0]   out_byte,
	input logic                         out_valid,
	input logic                         out_last
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_byte) && $stable(out_valid) &&
		$stable(out_last))
		else $error("result payload changed while stalled");

	// an empty end marker is always the closing word and carries a zero byte
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_valid |-> out_last && (out_byte == '0))
		else $error("malformed end marker");

	// an accepted final text word always brings a result
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && text_last |-> ##2 result_valid)
		else $error("no result after final text word");

endmodule

bind streaming_find_replace_core sfr_checker u_sfr_checker (.*);
